@@ design/gdd_pkg.sv @@
`default_nettype none
// Shared types, constants and rounding helpers for the grating diffraction core.
// Used by the core, its root and divide pipelines, and the port checker.
package gdd_pkg;

    // Fixed-point one in Q2.30 and its square in Q4.60.
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [63:0] ONE_SQ  = 64'h1000_0000_0000_0000;

    // Both long sections use one result bit per stage and share one latency.
    localparam int SQRT_ROOT_W = 32;
    localparam int DIV_QUO_W   = SQRT_ROOT_W;
    localparam int DIV_DEN_W   = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDX_GRATING = 2'd0;
    localparam logic [1:0] CFG_IDX_VLS     = 2'd1;
    localparam logic [1:0] CFG_IDX_CFF     = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_PARALLEL   = 2'd1,
        STATUS_EVANESCENT = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] inc_x;
        logic signed [31:0] inc_y;
        logic signed [31:0] inc_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
        logic signed [31:0] ruling_pos;
        logic signed [31:0] slope_error;
        logic               last_ray;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [30:0] cos_incidence;
        status_t            status;
        logic               last_out;
    } out_word_t;

    // Round a Q4.60 product to Q2.30, half up.
    function automatic logic signed [33:0] rnd_q30(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd536870912;
        return $signed(s[63:30]);
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < 64'shFFFF_FFFF_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/gdd_sqrt_pipe.sv @@
`default_nettype none
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on gdd_pkg for the default root width.
module gdd_sqrt_pipe
    import gdd_pkg::*;
#(
    parameter int ROOT_W = SQRT_ROOT_W
)
(
    input  wire                  clk,
    input  wire                  en,
    input  wire [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]    root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = ROOT_W + 4;

    logic [REM_W-1:0]    rem_reg  [ROOT_W-1];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg  [ROOT_W-1];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        logic [REM_W-1:0]    rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [2*ROOT_W-1:0] rad_in;
        logic [TRY_W-1:0]    acc;
        logic [TRY_W-1:0]    trial;
        logic                take;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign acc   = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (acc >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= {root_in[ROOT_W-2:0], take};
            end
        end

        if (s < ROOT_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? REM_W'(acc - trial) : acc[REM_W-1:0];
                    rad_reg[s] <= {rad_in[2*ROOT_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule
`default_nettype wire

@@ design/gdd_div_pipe.sv @@
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// The dividend must be below divisor times two to the quotient width.
module gdd_div_pipe
    import gdd_pkg::*;
#(
    parameter int QUO_W = DIV_QUO_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  wire                     clk,
    input  wire                     en,
    input  wire [QUO_W+DEN_W-1:0]   dividend,
    input  wire [DEN_W-1:0]         divisor,
    output logic [QUO_W-1:0]        quotient
);

    logic [DEN_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] low_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   acc;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in = dividend[QUO_W+DEN_W-1 -: DEN_W];
            assign den_in = divisor;
            assign low_in = dividend[QUO_W-1:0];
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign low_in = low_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        // Shift in one dividend bit and subtract when the divisor fits.
        assign acc  = {rem_in, low_in[QUO_W-1]};
        assign take = (acc >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= {quo_in[QUO_W-2:0], take};
            end
        end

        if (s < QUO_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? DEN_W'(acc - {1'b0, den_in}) : acc[DEN_W-1:0];
                    den_reg[s] <= den_in;
                    low_reg[s] <= {low_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];

endmodule
`default_nettype wire

@@ design/grating_diffraction_direction_core.sv @@
`default_nettype none
// Grating diffraction direction core: ray in, diffracted ray out, fully pipelined.
// Depends on gdd_pkg, gdd_sqrt_pipe and gdd_div_pipe.
//
// The core takes one ray per clock while no result is held at the output and
// returns one result per ray, in order. Most of its depth lies in two 32-stage
// sections that produce one bit per stage: the first forms the tangent norm
// and sin alpha by square root, the second divides the tangent by its norm
// while cos beta is rooted in parallel. When a result waits at the output
// with stall high, the whole pipeline holds and in_stall rises in the same
// cycle; nothing is dropped or repeated. Configuration writes are accepted
// in every cycle (cfg_ready is always high) and must be made while no ray
// is in flight. Status 1 marks an incident ray parallel to the normal, with
// a zero tangent; status 2 marks an evanescent order, with sin beta clamped.
module grating_diffraction_direction_core
    import gdd_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    input  wire in_word_t    in_data,
    output logic             out_valid,
    input  wire              out_stall,
    output out_word_t        out_data,
    input  wire              cfg_valid,
    output logic             cfg_ready,
    input  wire [1:0]        cfg_index,
    input  wire [31:0]       cfg_data
);

    localparam int LAT = SQRT_ROOT_W;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [33:0] gterm;
        logic signed [33:0] kterm;
        logic        [30:0] c;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               last;
    } side1_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] sb;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic        [31:0] norm;
        logic        [30:0] c;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               last;
    } side2_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] sb;
        logic               neg_x;
        logic               neg_y;
        logic               neg_z;
        logic        [30:0] c;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               last;
    } side3_t;

    logic en;

    // Configuration registers.
    logic signed [31:0] grating_reg;
    logic signed [31:0] vls_reg;
    logic signed [31:0] cff_reg;

    // Valid bits travel with the data.
    logic [5:0]     front_vld_reg;
    logic [LAT-1:0] side1_vld_reg;
    logic [2:0]     mid_vld_reg;
    logic [LAT-1:0] side3_vld_reg;
    logic [1:0]     back_vld_reg;
    logic           out_valid_reg;

    // Stage A: raw products.
    logic signed [63:0] a_pv_next  [6];
    logic signed [63:0] a_dot_next [3];
    logic signed [32:0] a_cff_one;
    logic signed [63:0] a_bz_next;
    logic signed [64:0] a_k_next;
    logic signed [63:0] a_pv_reg   [6];
    logic signed [63:0] a_dot_reg  [3];
    logic signed [63:0] a_bz_reg;
    logic signed [64:0] a_k_reg;
    logic signed [31:0] a_n_reg    [3];
    logic               a_last_reg;

    // Stage B: N x I, cos alpha, line-density and slope factors.
    logic signed [31:0] b_v_next [3];
    logic signed [35:0] b_c_sum;
    logic        [35:0] b_c_abs;
    logic        [30:0] b_c_next;
    logic signed [63:0] b_bz_sum;
    logic signed [63:0] b_f_wide;
    logic signed [64:0] b_k_sum;
    logic signed [63:0] b_k_wide;
    logic signed [31:0] b_v_reg [3];
    logic        [30:0] b_c_reg;
    logic signed [31:0] b_f_reg;
    logic signed [31:0] b_k_reg;
    logic signed [31:0] b_n_reg [3];
    logic               b_last_reg;

    // Stage C: products for the tangent, cos squared, grating and slope terms.
    logic signed [63:0] c_pt_reg [6];
    logic        [61:0] c_cc_reg;
    logic signed [63:0] c_gf_reg;
    logic signed [63:0] c_kc_reg;
    logic        [30:0] c_c_reg;
    logic signed [31:0] c_n_reg [3];
    logic               c_last_reg;

    // Stages D to F: tangent, its squared length, radicand of sin alpha.
    side1_t             d_side_next;
    side1_t             d_side_reg;
    logic        [63:0] d_rad_reg;
    side1_t             e_side_reg;
    logic        [63:0] e_rad_reg;
    logic        [63:0] e_sq_reg [3];
    side1_t             f_side_reg;
    logic        [63:0] f_rad_reg;
    logic        [63:0] f_sum_reg;
    side1_t             side1_reg [LAT];
    logic        [31:0] norm_root;
    logic        [31:0] sa_root;

    // Stages G to I: sin beta, its square, divider operands.
    logic signed [35:0] g_sb_full;
    logic               g_hi;
    logic               g_lo;
    side2_t             g_side_next;
    side2_t             g_side_reg;
    side2_t             h_side_reg;
    logic        [63:0] h_sbsq_reg;
    logic        [31:0] i_mag [3];
    logic        [63:0] i_num_next [3];
    side3_t             i_side_next;
    logic        [63:0] i_rad_reg;
    logic        [63:0] i_num_reg [3];
    logic        [31:0] i_den_reg;
    side3_t             i_side_reg;
    side3_t             side3_reg [LAT];
    logic        [31:0] cb_root;
    logic        [31:0] quo [3];

    // Stages J to L: unit tangent, output products, sums.
    logic signed [31:0] j_tu_next [3];
    logic        [31:0] j_cb_reg;
    logic signed [31:0] j_tu_reg [3];
    side3_t             j_side_reg;
    logic signed [63:0] k_cn_reg [3];
    logic signed [63:0] k_st_reg [3];
    logic        [30:0] k_c_reg;
    status_t            k_status_reg;
    logic               k_last_reg;
    out_word_t          out_data_next;
    out_word_t          out_data_reg;

    // The whole pipeline moves unless a finished word is held at the output.
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grating_reg <= '0;
            vls_reg     <= '0;
            cff_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDX_GRATING: grating_reg <= cfg_data;
                CFG_IDX_VLS:     vls_reg     <= cfg_data;
                CFG_IDX_CFF:     cff_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= '0;
            side1_vld_reg <= '0;
            mid_vld_reg   <= '0;
            side3_vld_reg <= '0;
            back_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            front_vld_reg <= {front_vld_reg[4:0], in_valid};
            side1_vld_reg <= {side1_vld_reg[LAT-2:0], front_vld_reg[5]};
            mid_vld_reg   <= {mid_vld_reg[1:0], side1_vld_reg[LAT-1]};
            side3_vld_reg <= {side3_vld_reg[LAT-2:0], mid_vld_reg[2]};
            back_vld_reg  <= {back_vld_reg[0], side3_vld_reg[LAT-1]};
            out_valid_reg <= back_vld_reg[1];
        end
    end

    // Stage A: all products of the input word, some with configuration registers.
    assign a_pv_next[0]  = in_data.inc_z * in_data.norm_y;
    assign a_pv_next[1]  = in_data.inc_y * in_data.norm_z;
    assign a_pv_next[2]  = in_data.inc_x * in_data.norm_z;
    assign a_pv_next[3]  = in_data.inc_z * in_data.norm_x;
    assign a_pv_next[4]  = in_data.inc_y * in_data.norm_x;
    assign a_pv_next[5]  = in_data.inc_x * in_data.norm_y;
    assign a_dot_next[0] = in_data.inc_x * in_data.norm_x;
    assign a_dot_next[1] = in_data.inc_y * in_data.norm_y;
    assign a_dot_next[2] = in_data.inc_z * in_data.norm_z;
    assign a_bz_next     = vls_reg * in_data.ruling_pos;
    assign a_cff_one     = 33'sh0_0100_0000 + 33'(cff_reg);
    assign a_k_next      = a_cff_one * in_data.slope_error;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pv_reg   <= a_pv_next;
            a_dot_reg  <= a_dot_next;
            a_bz_reg   <= a_bz_next;
            a_k_reg    <= a_k_next;
            a_n_reg[0] <= in_data.norm_x;
            a_n_reg[1] <= in_data.norm_y;
            a_n_reg[2] <= in_data.norm_z;
            a_last_reg <= in_data.last_ray;
        end
    end

    // Stage B: round and saturate N x I; fold cos alpha into [0, 1].
    assign b_v_next[0] = sat32(64'(rnd_q30(a_pv_reg[0])) - 64'(rnd_q30(a_pv_reg[1])));
    assign b_v_next[1] = sat32(64'(rnd_q30(a_pv_reg[2])) - 64'(rnd_q30(a_pv_reg[3])));
    assign b_v_next[2] = sat32(64'(rnd_q30(a_pv_reg[4])) - 64'(rnd_q30(a_pv_reg[5])));
    assign b_c_sum     = 36'(rnd_q30(a_dot_reg[0])) + 36'(rnd_q30(a_dot_reg[1]))
                       + 36'(rnd_q30(a_dot_reg[2]));
    assign b_bz_sum    = a_bz_reg + 64'sd32768;
    assign b_f_wide    = 64'($signed(b_bz_sum[63:16])) + 64'(ONE_Q30);
    assign b_k_sum     = a_k_reg + 65'sd8388608;
    assign b_k_wide    = 64'($signed(b_k_sum[64:24]));

    always_comb
    begin
        b_c_abs  = b_c_sum[35] ? 36'(-b_c_sum) : 36'(b_c_sum);
        b_c_next = (b_c_abs > 36'(ONE_Q30)) ? ONE_Q30 : b_c_abs[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_v_reg    <= b_v_next;
            b_c_reg    <= b_c_next;
            b_f_reg    <= sat32(b_f_wide);
            b_k_reg    <= sat32(b_k_wide);
            b_n_reg    <= a_n_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // Stage C: products for (N x I) x N, cos squared, grating and slope terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_pt_reg[0] <= b_n_reg[2] * b_v_reg[1];
            c_pt_reg[1] <= b_n_reg[1] * b_v_reg[2];
            c_pt_reg[2] <= b_n_reg[0] * b_v_reg[2];
            c_pt_reg[3] <= b_n_reg[2] * b_v_reg[0];
            c_pt_reg[4] <= b_n_reg[1] * b_v_reg[0];
            c_pt_reg[5] <= b_n_reg[0] * b_v_reg[1];
            c_cc_reg    <= b_c_reg * b_c_reg;
            c_gf_reg    <= grating_reg * b_f_reg;
            c_kc_reg    <= b_k_reg * $signed({1'b0, b_c_reg});
            c_c_reg     <= b_c_reg;
            c_n_reg     <= b_n_reg;
            c_last_reg  <= b_last_reg;
        end
    end

    // Stage D: tangent components and the rounded grating and slope terms.
    always_comb
    begin
        d_side_next.tx    = sat32(64'(rnd_q30(c_pt_reg[0])) - 64'(rnd_q30(c_pt_reg[1])));
        d_side_next.ty    = sat32(64'(rnd_q30(c_pt_reg[2])) - 64'(rnd_q30(c_pt_reg[3])));
        d_side_next.tz    = sat32(64'(rnd_q30(c_pt_reg[4])) - 64'(rnd_q30(c_pt_reg[5])));
        d_side_next.gterm = rnd_q30(c_gf_reg);
        d_side_next.kterm = rnd_q30(c_kc_reg);
        d_side_next.c     = c_c_reg;
        d_side_next.nx    = c_n_reg[0];
        d_side_next.ny    = c_n_reg[1];
        d_side_next.nz    = c_n_reg[2];
        d_side_next.last  = c_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg <= d_side_next;
            d_rad_reg  <= ONE_SQ - 64'(c_cc_reg);
        end
    end

    // Stage E: squares of the tangent components.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_sq_reg[0] <= d_side_reg.tx * d_side_reg.tx;
            e_sq_reg[1] <= d_side_reg.ty * d_side_reg.ty;
            e_sq_reg[2] <= d_side_reg.tz * d_side_reg.tz;
            e_side_reg  <= d_side_reg;
            e_rad_reg   <= d_rad_reg;
        end
    end

    // Stage F: squared tangent length.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_sum_reg  <= e_sq_reg[0] + e_sq_reg[1] + e_sq_reg[2];
            f_side_reg <= e_side_reg;
            f_rad_reg  <= e_rad_reg;
        end
    end

    // Tangent norm and sin alpha, side data delayed alongside.
    gdd_sqrt_pipe #(.ROOT_W(SQRT_ROOT_W)) u_norm_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (f_sum_reg),
        .root     (norm_root)
    );

    gdd_sqrt_pipe #(.ROOT_W(SQRT_ROOT_W)) u_sa_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (f_rad_reg),
        .root     (sa_root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg[0] <= f_side_reg;
            for (int i = 1; i < LAT; i++)
            begin
                side1_reg[i] <= side1_reg[i-1];
            end
        end
    end

    // Stage G: sin beta with clamping and the status code.
    assign g_sb_full = $signed(36'(sa_root)) - 36'(side1_reg[LAT-1].gterm)
                     - 36'(side1_reg[LAT-1].kterm);

    always_comb
    begin
        g_hi = (g_sb_full > $signed(36'(ONE_Q30)));
        g_lo = (g_sb_full < -$signed(36'(ONE_Q30)));
        priority if (norm_root == '0)
            g_side_next.status = STATUS_PARALLEL;
        else if (g_hi || g_lo)
            g_side_next.status = STATUS_EVANESCENT;
        else
            g_side_next.status = STATUS_OK;
        priority if (g_hi)
            g_side_next.sb = $signed(32'(ONE_Q30));
        else if (g_lo)
            g_side_next.sb = -$signed(32'(ONE_Q30));
        else
            g_side_next.sb = g_sb_full[31:0];
        g_side_next.tx   = side1_reg[LAT-1].tx;
        g_side_next.ty   = side1_reg[LAT-1].ty;
        g_side_next.tz   = side1_reg[LAT-1].tz;
        g_side_next.norm = norm_root;
        g_side_next.c    = side1_reg[LAT-1].c;
        g_side_next.nx   = side1_reg[LAT-1].nx;
        g_side_next.ny   = side1_reg[LAT-1].ny;
        g_side_next.nz   = side1_reg[LAT-1].nz;
        g_side_next.last = side1_reg[LAT-1].last;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_side_reg <= g_side_next;
        end
    end

    // Stage H: sin beta squared.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_sbsq_reg <= g_side_reg.sb * g_side_reg.sb;
            h_side_reg <= g_side_reg;
        end
    end

    // Stage I: radicand of cos beta and the rounded-division operands.
    assign i_mag[0] = h_side_reg.tx[31] ? 32'(-h_side_reg.tx) : 32'(h_side_reg.tx);
    assign i_mag[1] = h_side_reg.ty[31] ? 32'(-h_side_reg.ty) : 32'(h_side_reg.ty);
    assign i_mag[2] = h_side_reg.tz[31] ? 32'(-h_side_reg.tz) : 32'(h_side_reg.tz);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            i_num_next[i] = {2'b00, i_mag[i], 30'b0} + 64'(h_side_reg.norm >> 1);
        end
        i_side_next.status = h_side_reg.status;
        i_side_next.sb     = h_side_reg.sb;
        i_side_next.neg_x  = h_side_reg.tx[31];
        i_side_next.neg_y  = h_side_reg.ty[31];
        i_side_next.neg_z  = h_side_reg.tz[31];
        i_side_next.c      = h_side_reg.c;
        i_side_next.nx     = h_side_reg.nx;
        i_side_next.ny     = h_side_reg.ny;
        i_side_next.nz     = h_side_reg.nz;
        i_side_next.last   = h_side_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_rad_reg  <= ONE_SQ - h_sbsq_reg;
            i_num_reg  <= i_num_next;
            i_den_reg  <= h_side_reg.norm;
            i_side_reg <= i_side_next;
        end
    end

    // Cos beta and the three tangent quotients run side by side.
    gdd_sqrt_pipe #(.ROOT_W(SQRT_ROOT_W)) u_cb_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (i_rad_reg),
        .root     (cb_root)
    );

    for (genvar d = 0; d < 3; d++) begin : g_div
        gdd_div_pipe #(.QUO_W(DIV_QUO_W), .DEN_W(DIV_DEN_W)) u_div
        (
            .clk      (clk),
            .en       (en),
            .dividend (i_num_reg[d]),
            .divisor  (i_den_reg),
            .quotient (quo[d])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg[0] <= i_side_reg;
            for (int i = 1; i < LAT; i++)
            begin
                side3_reg[i] <= side3_reg[i-1];
            end
        end
    end

    // Stage J: signed unit tangent, zero when the tangent vanished.
    always_comb
    begin
        if (side3_reg[LAT-1].status == STATUS_PARALLEL)
        begin
            j_tu_next[0] = '0;
            j_tu_next[1] = '0;
            j_tu_next[2] = '0;
        end
        else
        begin
            j_tu_next[0] = side3_reg[LAT-1].neg_x ? $signed(-quo[0]) : $signed(quo[0]);
            j_tu_next[1] = side3_reg[LAT-1].neg_y ? $signed(-quo[1]) : $signed(quo[1]);
            j_tu_next[2] = side3_reg[LAT-1].neg_z ? $signed(-quo[2]) : $signed(quo[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_cb_reg   <= cb_root;
            j_tu_reg   <= j_tu_next;
            j_side_reg <= side3_reg[LAT-1];
        end
    end

    // Stage K: cos beta times N and sin beta times t.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_cn_reg[0]  <= $signed({1'b0, j_cb_reg}) * j_side_reg.nx;
            k_cn_reg[1]  <= $signed({1'b0, j_cb_reg}) * j_side_reg.ny;
            k_cn_reg[2]  <= $signed({1'b0, j_cb_reg}) * j_side_reg.nz;
            k_st_reg[0]  <= j_side_reg.sb * j_tu_reg[0];
            k_st_reg[1]  <= j_side_reg.sb * j_tu_reg[1];
            k_st_reg[2]  <= j_side_reg.sb * j_tu_reg[2];
            k_c_reg      <= j_side_reg.c;
            k_status_reg <= j_side_reg.status;
            k_last_reg   <= j_side_reg.last;
        end
    end

    // Stage L: output word.
    always_comb
    begin
        out_data_next.out_x = sat32(64'(rnd_q30(k_cn_reg[0])) + 64'(rnd_q30(k_st_reg[0])));
        out_data_next.out_y = sat32(64'(rnd_q30(k_cn_reg[1])) + 64'(rnd_q30(k_st_reg[1])));
        out_data_next.out_z = sat32(64'(rnd_q30(k_cn_reg[2])) + 64'(rnd_q30(k_st_reg[2])));
        out_data_next.cos_incidence = k_c_reg;
        out_data_next.status        = k_status_reg;
        out_data_next.last_out      = k_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
`default_nettype wire

@@ design/gdd_checker.sv @@
`default_nettype none
// Port-level checks for the grating diffraction core, bound to its top level.
// Depends on gdd_pkg for the word types and the Q2.30 one.
module gdd_checker
    import gdd_pkg::*;
(
    input wire            clk,
    input wire            rst_n,
    input wire            in_stall,
    input wire            out_valid,
    input wire            out_stall,
    input wire out_word_t out_data
);

    // Cos alpha is clamped to one.
    a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.cos_incidence <= ONE_Q30)
        else $error("cos_incidence above one");

    // The input side only stalls behind a held output word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no output word waiting");

    // A stalled output word stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped under stall");

    // A stalled output word does not change.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output word changed under stall");

endmodule

bind grating_diffraction_direction_core gdd_checker u_gdd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
